[sv/imucrc_pkg.sv]
`timescale 1ns / 1ps

package imucrc_pkg;

    localparam int DATA_WORDS = 11;
    localparam int WORD_W     = 16;
    localparam int POS_W      = 4;

    localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_STATUS = pos_t'(0);
    localparam pos_t POS_FIRST  = pos_t'(1);
    localparam pos_t POS_LAST   = pos_t'(DATA_WORDS + 1);

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              frame_start;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] status_word;
        logic [WORD_W-1:0] computed_crc;
        logic [WORD_W-1:0] received_crc;
        logic              crc_match;
    } result_t;

    // one byte, lsb first, reflected shift with the 0x1021 tap pattern
    function automatic logic [WORD_W-1:0] crc_byte(
        input logic [WORD_W-1:0] crc,
        input logic [7:0]        data
    );
        logic [WORD_W-1:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ data[k])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // low byte first, then high byte
    function automatic logic [WORD_W-1:0] crc_word(
        input logic [WORD_W-1:0] crc,
        input logic [WORD_W-1:0] data
    );
        return crc_byte(crc_byte(crc, data[7:0]), data[15:8]);
    endfunction

endpackage

[sv/imu_burst_frame_crc_check_core.sv]
`timescale 1ns / 1ps
// burst frame crc checker
// input channel: in_valid / in_stall with word and frame_start, one burst word per
// transfer: status word, then the data words, then the received crc word.
// frame_start forces a word to be taken as a status word; after a frame ends the
// next word is a status word anyway, so back-to-back frames need no flag.
// output channel: out_valid / out_stall, one result per frame carrying the status
// word, the complemented byte-swapped crc, the received crc and crc_match.
// throughput: one word per cycle while in_stall is low; the crc of a whole word is one combinational
// update between the input register and the crc register.
// result path: a crc word accepted into the input register has its result loaded into the
// output register when there is room, and the result transfers from there.
// stall: a result waits in the output register while out_stall is high; words
// still flow until the next crc word reaches the input register, then in_stall rises.
// reset: position returns to the status word, crc to its seed, both channels empty.
module imu_burst_frame_crc_check_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] word,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] status_word,
    output logic [15:0] computed_crc,
    output logic [15:0] received_crc,
    output logic        crc_match
);

    imucrc_pkg::item_t   item;
    imucrc_pkg::item_t   held_item;
    imucrc_pkg::result_t res;
    imucrc_pkg::result_t res_out;
    logic                held_valid;
    logic                consume;
    logic                res_load;
    logic                out_space;

    assign item.word        = word;
    assign item.frame_start = frame_start;

    imucrc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .item       (item),
        .consume    (consume),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    imucrc_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_item  (held_item),
        .out_space  (out_space),
        .consume    (consume),
        .res_load   (res_load),
        .res        (res)
    );

    imucrc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .out_space (out_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign status_word  = res_out.status_word;
    assign computed_crc = res_out.computed_crc;
    assign received_crc = res_out.received_crc;
    assign crc_match    = res_out.crc_match;

endmodule

[sv/imucrc_in_reg.sv]
`timescale 1ns / 1ps

module imucrc_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  imucrc_pkg::item_t   item,
    input  logic                consume,
    output logic                held_valid,
    output imucrc_pkg::item_t   held_item
);

    logic              valid_reg;
    logic              valid_next;
    imucrc_pkg::item_t item_reg;
    logic              load;

    // the register takes a new transfer when empty or when its word is consumed
    assign load     = !valid_reg || consume;
    assign in_stall = !load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[sv/imucrc_frame.sv]
`timescale 1ns / 1ps

module imucrc_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                held_valid,
    input  imucrc_pkg::item_t   held_item,
    input  logic                out_space,
    output logic                consume,
    output logic                res_load,
    output imucrc_pkg::result_t res
);

    imucrc_pkg::pos_t                  pos_reg;
    imucrc_pkg::pos_t                  pos_next;
    logic [imucrc_pkg::WORD_W-1:0]     crc_reg;
    logic [imucrc_pkg::WORD_W-1:0]     crc_next;
    logic [imucrc_pkg::WORD_W-1:0]     status_reg;
    logic [imucrc_pkg::WORD_W-1:0]     status_next;
    logic [imucrc_pkg::WORD_W-1:0]     crc_inv;
    logic [imucrc_pkg::WORD_W-1:0]     crc_swapped;
    logic                              is_start;
    logic                              is_data;
    logic                              is_last;

    // a word at position zero opens a frame even without the flag
    assign is_start = held_item.frame_start || (pos_reg == imucrc_pkg::POS_STATUS);
    assign is_data  = !is_start && (pos_reg <= imucrc_pkg::pos_t'(imucrc_pkg::DATA_WORDS));
    assign is_last  = !is_start && !is_data;

    // only the crc word needs room at the output
    assign consume  = held_valid && (!is_last || out_space);
    assign res_load = consume && is_last;

    assign crc_inv     = ~crc_reg;
    assign crc_swapped = {crc_inv[7:0], crc_inv[15:8]};

    assign res.status_word  = status_reg;
    assign res.computed_crc = crc_swapped;
    assign res.received_crc = held_item.word;
    assign res.crc_match    = (crc_swapped == held_item.word);

    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        status_next = status_reg;
        if (consume)
        begin
            priority if (is_start)
            begin
                status_next = held_item.word;
                crc_next    = imucrc_pkg::CRC_INIT;
                pos_next    = imucrc_pkg::POS_FIRST;
            end
            else if (is_data)
            begin
                crc_next = imucrc_pkg::crc_word(crc_reg, held_item.word);
                pos_next = pos_reg + imucrc_pkg::pos_t'(1);
            end
            else
            begin
                crc_next = imucrc_pkg::CRC_INIT;
                pos_next = imucrc_pkg::POS_STATUS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= imucrc_pkg::POS_STATUS;
            crc_reg    <= imucrc_pkg::CRC_INIT;
            status_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
        end
    end

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (pos_reg == imucrc_pkg::POS_STATUS) && (crc_reg == imucrc_pkg::CRC_INIT))
        else $error("frame end did not rewind position and crc");

    a_start_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        consume && is_start |=> (pos_reg == imucrc_pkg::POS_FIRST)
            && (crc_reg == imucrc_pkg::CRC_INIT))
        else $error("frame start did not seed position and crc");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= imucrc_pkg::POS_LAST)
        else $error("word position ran past the crc word");

    a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !consume |-> is_last && !out_space)
        else $error("held word blocked without a full output");

endmodule

[sv/imucrc_out_reg.sv]
`timescale 1ns / 1ps

module imucrc_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_load,
    input  imucrc_pkg::result_t res,
    output logic                out_space,
    output logic                out_valid,
    input  logic                out_stall,
    output imucrc_pkg::result_t res_out
);

    logic                valid_reg;
    logic                valid_next;
    imucrc_pkg::result_t res_reg;

    assign out_space = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

[tb/imu_burst_frame_crc_check_core_tb.sv]
`timescale 1ns / 1ps

class burst_crc_scoreboard;

    imucrc_pkg::pos_t              position    = imucrc_pkg::POS_STATUS;
    logic [imucrc_pkg::WORD_W-1:0] crc_acc     = imucrc_pkg::CRC_INIT;
    logic [imucrc_pkg::WORD_W-1:0] held_status = '0;
    imucrc_pkg::result_t           frames_due[$];
    int                            errors      = 0;

    // bits 0..15 in order is the same as low byte then high byte, each lsb first
    function logic [imucrc_pkg::WORD_W-1:0] fold_word(
        input logic [imucrc_pkg::WORD_W-1:0] crc,
        input logic [imucrc_pkg::WORD_W-1:0] w
    );
        logic [imucrc_pkg::WORD_W-1:0] c;
        c = crc;
        for (int k = 0; k < imucrc_pkg::WORD_W; k++)
        begin
            c = (c[0] ^ w[k]) ? ((c >> 1) ^ imucrc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function logic [imucrc_pkg::WORD_W-1:0] seal(input logic [imucrc_pkg::WORD_W-1:0] crc);
        logic [imucrc_pkg::WORD_W-1:0] inv;
        inv = ~crc;
        return {inv[7:0], inv[15:8]};
    endfunction

    function void note_word(input logic [imucrc_pkg::WORD_W-1:0] w, input logic fs);
        imucrc_pkg::result_t           r;
        logic [imucrc_pkg::WORD_W-1:0] sealed;
        if (fs || position == imucrc_pkg::POS_STATUS)
        begin
            held_status = w;
            crc_acc     = imucrc_pkg::CRC_INIT;
            position    = imucrc_pkg::POS_FIRST;
        end
        else if (position < imucrc_pkg::POS_LAST)
        begin
            crc_acc  = fold_word(crc_acc, w);
            position = position + imucrc_pkg::pos_t'(1);
        end
        else
        begin
            // anything past the data words is the received crc
            sealed         = seal(crc_acc);
            r.status_word  = held_status;
            r.computed_crc = sealed;
            r.received_crc = w;
            r.crc_match    = (sealed == w);
            frames_due.push_back(r);
            position = imucrc_pkg::POS_STATUS;
            crc_acc  = imucrc_pkg::CRC_INIT;
        end
    endfunction

    function void check_result(
        input logic [imucrc_pkg::WORD_W-1:0] sw,
        input logic [imucrc_pkg::WORD_W-1:0] cc,
        input logic [imucrc_pkg::WORD_W-1:0] rc,
        input logic                          m
    );
        imucrc_pkg::result_t want;
        if (frames_due.size() == 0)
        begin
            $error("result with no frame pending: status_word %h", sw);
            errors++;
        end
        else
        begin
            want = frames_due.pop_front();
            if (sw !== want.status_word)
            begin
                $error("status_word: expected %h, got %h", want.status_word, sw);
                errors++;
            end
            if (cc !== want.computed_crc)
            begin
                $error("computed_crc: expected %h, got %h", want.computed_crc, cc);
                errors++;
            end
            if (rc !== want.received_crc)
            begin
                $error("received_crc: expected %h, got %h", want.received_crc, rc);
                errors++;
            end
            if (m !== want.crc_match)
            begin
                $error("crc_match: expected %b, got %b", want.crc_match, m);
                errors++;
            end
        end
    endfunction

    function int pending();
        return frames_due.size();
    endfunction

endclass

module imu_burst_frame_crc_check_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 380;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {CRC_NONE, CRC_GOOD, CRC_FLIP, CRC_RANDOM} crc_kind_t;
    typedef enum int {FILL_EXTREME, FILL_RANDOM} fill_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] word;
    logic        frame_start;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] status_word;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        crc_match;

    burst_crc_scoreboard sb;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int words_sent         = 0;
    int cycle_count        = 0;
    int hold_left          = 0;
    int hold_reqs          = 0;
    int holds_started      = 0;
    bit need_flag          = 1'b0;

    imu_burst_frame_crc_check_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .word         (word),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status_word  (status_word),
        .computed_crc (computed_crc),
        .received_crc (received_crc),
        .crc_match    (crc_match)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_word(word, frame_start);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(status_word, computed_crc, received_crc, crc_match);
            end
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_reqs != holds_started)
        begin
            hold_left     = HOLD_CYCLES;
            holds_started = hold_reqs;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic put_word(input logic [15:0] w, input logic fs);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        word        <= w;
        frame_start <= fs;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        words_sent++;
    endtask

    // status word, n_data data words, then the crc word unless kind is CRC_NONE
    task automatic send_frame(input logic [15:0] status, input logic flag, input int n_data,
                              input crc_kind_t kind, input fill_t fill);
        logic [15:0] acc;
        logic [15:0] d;
        logic [15:0] good;
        put_word(status, flag);
        acc = imucrc_pkg::CRC_INIT;
        for (int k = 0; k < n_data; k++)
        begin
            if (fill == FILL_EXTREME)
            begin
                d = (k % 2 == 1) ? 16'hFFFF : 16'h0000;
            end
            else
            begin
                d = pick_word();
            end
            acc = sb.fold_word(acc, d);
            put_word(d, 1'b0);
        end
        good = sb.seal(acc);
        case (kind)
            CRC_GOOD:   put_word(good, 1'b0);
            CRC_FLIP:   put_word(good ^ (16'h0001 << $urandom_range(15)), 1'b0);
            CRC_RANDOM: put_word(pick_word(), 1'b0);
            default:    ;
        endcase
        // a cut-off frame leaves the block mid-frame, so the next one needs the flag
        need_flag = (kind == CRC_NONE);
    endtask

    task automatic random_frame();
        int        r;
        logic      flag;
        crc_kind_t kind;
        flag = need_flag ? 1'b1 : 1'($urandom_range(1));
        r    = $urandom_range(99);
        if (r < 10)
        begin
            send_frame(pick_word(), flag, $urandom_range(imucrc_pkg::DATA_WORDS), CRC_NONE,
                       FILL_RANDOM);
        end
        else
        begin
            if (r < 70)
            begin
                kind = CRC_GOOD;
            end
            else if (r < 88)
            begin
                kind = CRC_FLIP;
            end
            else
            begin
                kind = CRC_RANDOM;
            end
            send_frame(pick_word(), flag, imucrc_pkg::DATA_WORDS, kind, FILL_RANDOM);
        end
    endtask

    initial
    begin
        int target;
        sb          = new;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        word        = '0;
        frame_start = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // flagged frame of extreme data, an unflagged start cut short,
        // then a restart mid-frame with a bad crc, then an unflagged good frame
        send_frame(16'hFFFF, 1'b1, imucrc_pkg::DATA_WORDS, CRC_GOOD, FILL_EXTREME);
        send_frame(16'h0000, 1'b0, 2, CRC_NONE, FILL_RANDOM);
        send_frame(16'hA5C3, 1'b1, imucrc_pkg::DATA_WORDS, CRC_FLIP, FILL_RANDOM);
        send_frame(16'h5A3C, 1'b0, imucrc_pkg::DATA_WORDS, CRC_GOOD, FILL_RANDOM);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    // back up the output so the input stalls
                    hold_reqs++;
                end
                1:
                begin
                    sender_idle_pct    = 60;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 60;
                end
                default:
                begin
                    sender_idle_pct    = 29;
                    receiver_stall_pct = 29;
                end
            endcase
            target = words_sent + PHASE_ITEMS;
            while (words_sent < target)
            begin
                random_frame();
            end
            if (ph == 1)
            begin
                // sender pauses until every result is out
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                begin
                    @(posedge clk);
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        receiver_stall_pct = 0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/imucrc_pkg.sv
sv/imucrc_in_reg.sv
sv/imucrc_frame.sv
sv/imucrc_out_reg.sv
sv/imu_burst_frame_crc_check_core.sv
tb/imu_burst_frame_crc_check_core_tb.sv
